/* rtl/breakpoint_envelope_generator_unit_assert.svh */
// ----------------------------------------------------------------------------
// breakpoint envelope generator assertion macros
// clocked on i_clk, disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef BREAKPOINT_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH
`define BREAKPOINT_ENVELOPE_GENERATOR_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BEGU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BEGU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/begu_pkg.sv */
// ----------------------------------------------------------------------------
// begu_pkg
// shared widths, codes, controller states and command/status bundles
// ----------------------------------------------------------------------------
package begu_pkg;

    localparam int TIME_W    = 40;
    localparam int VAL_W     = 32;
    localparam int ACT_W     = 2;
    localparam int PIDX_W    = 6;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 40;

    // multiplier: offset magnitude times height magnitude
    localparam int OFF_W     = TIME_W;
    localparam int HGT_W     = VAL_W + 1;
    localparam int PROD_W    = OFF_W + 1 + HGT_W;
    localparam int QUO_W     = TIME_W + 1;
    localparam int SUM_W     = QUO_W + 2;
    localparam int MUL_STEPS = HGT_W;
    localparam int DIV_STEPS = PROD_W;
    localparam int STEP_CNT_W = 7;

    localparam logic [ACT_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RESTART = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 1'd1;

    localparam logic [TIME_W-1:0] TIME_STEP_RESET   = 40'd349525;
    localparam logic [CNT_W-1:0]  POINT_COUNT_RESET = 7'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_UPDATE,
        ST_LD_L,
        ST_LD_R,
        ST_LD_FIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic write;
        logic restart;
        logic hold;
        logic prep;
        logic mul_step;
        logic div_step;
        logic sum;
        logic update;
        logic rd_right;
        logic cap_left;
        logic cap_right;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic more_spans;
        logic zero_width;
        logic reload;
    } t_dp_status;

endpackage

/* rtl/begu_ctrl.sv */
// ----------------------------------------------------------------------------
// begu_ctrl
// sequencer: input handshake, multiply/divide step counting, span reload
// and the output beat register
// ----------------------------------------------------------------------------
module begu_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [begu_pkg::ACT_W-1:0]    i_action,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  begu_pkg::t_dp_status          i_status,
    output begu_pkg::t_dp_cmd             o_cmd
);

    begu_pkg::t_state                   r_state, n_state;
    logic [begu_pkg::STEP_CNT_W-1:0]    r_cnt, n_cnt;
    logic                               r_tick, n_tick;
    logic                               r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= begu_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_tick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_tick      <= n_tick;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_tick      = r_tick;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            begu_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        begu_pkg::ACT_WRITE: begin
                            o_cmd.write = 1'b1;
                        end
                        begu_pkg::ACT_RESTART: begin
                            o_cmd.restart = 1'b1;
                            n_tick        = 1'b0;
                            n_state       = begu_pkg::ST_LD_L;
                        end
                        begu_pkg::ACT_TICK: begin
                            n_tick = 1'b1;
                            if (!i_status.more_spans) begin
                                o_cmd.hold = 1'b1;
                                n_state    = begu_pkg::ST_DONE;
                            end else begin
                                n_state = begu_pkg::ST_PREP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            begu_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_cnt      = '0;
                n_state    = i_status.zero_width ? begu_pkg::ST_UPDATE : begu_pkg::ST_MUL;
            end
            begu_pkg::ST_MUL: begin
                o_cmd.mul_step = 1'b1;
                if (r_cnt == begu_pkg::STEP_CNT_W'(begu_pkg::MUL_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = begu_pkg::ST_DIV;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            begu_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == begu_pkg::STEP_CNT_W'(begu_pkg::DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = begu_pkg::ST_SUM;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            begu_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = begu_pkg::ST_UPDATE;
            end
            begu_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.reload ? begu_pkg::ST_LD_L : begu_pkg::ST_DONE;
            end
            begu_pkg::ST_LD_L: begin
                // left entry address goes to the table
                n_state = begu_pkg::ST_LD_R;
            end
            begu_pkg::ST_LD_R: begin
                o_cmd.rd_right = 1'b1;
                o_cmd.cap_left = 1'b1;
                n_state        = begu_pkg::ST_LD_FIN;
            end
            begu_pkg::ST_LD_FIN: begin
                o_cmd.cap_right = 1'b1;
                n_state         = r_tick ? begu_pkg::ST_DONE : begu_pkg::ST_IDLE;
            end
            begu_pkg::ST_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = begu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = begu_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready  = (r_state == begu_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

/* rtl/begu_datapath.sv */
// ----------------------------------------------------------------------------
// begu_datapath
// breakpoint table, span and position registers, config registers,
// shift-add multiplier and restoring divider, output payload register
// ----------------------------------------------------------------------------
module begu_datapath #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  begu_pkg::t_dp_cmd                   i_cmd,
    output begu_pkg::t_dp_status                o_status,
    input  logic                                i_cfg_we,
    input  logic [begu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [begu_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic [begu_pkg::PIDX_W-1:0]         i_point_index,
    input  logic [begu_pkg::TIME_W-1:0]         i_point_time,
    input  logic signed [begu_pkg::VAL_W-1:0]   i_point_value,
    output logic signed [begu_pkg::VAL_W-1:0]   o_sample,
    output logic                                o_ended
);

    localparam int TIME_W = begu_pkg::TIME_W;
    localparam int VAL_W  = begu_pkg::VAL_W;
    localparam int OFF_W  = begu_pkg::OFF_W;
    localparam int HGT_W  = begu_pkg::HGT_W;
    localparam int PROD_W = begu_pkg::PROD_W;
    localparam int QUO_W  = begu_pkg::QUO_W;
    localparam int SUM_W  = begu_pkg::SUM_W;
    localparam int MEM_W  = TIME_W + VAL_W;
    localparam int ADDR_W = $clog2(MAX_POINTS);
    localparam int IDX_W  = $clog2(MAX_POINTS + 1);
    localparam int CMP_W  = (IDX_W > begu_pkg::CNT_W) ? IDX_W : begu_pkg::CNT_W;

    // breakpoint table, {time, value} per entry
    logic [MEM_W-1:0]           r_mem [MAX_POINTS];
    logic [MEM_W-1:0]           r_rd_data;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       wr_ok;

    logic [TIME_W-1:0]          r_time_step;
    logic [begu_pkg::CNT_W-1:0] r_point_count;

    logic [TIME_W-1:0]          r_pos;
    logic [IDX_W-1:0]           r_idx;
    logic                       r_more;
    logic [TIME_W-1:0]          r_start_time;
    logic [TIME_W-1:0]          r_end_time;
    logic [VAL_W-1:0]           r_start_value;
    logic [VAL_W-1:0]           r_end_value;

    logic [OFF_W-1:0]           r_a;
    logic [PROD_W-1:0]          r_p;
    logic [TIME_W-1:0]          r_w;
    logic                       r_neg;
    logic [TIME_W-1:0]          r_rem;
    logic [QUO_W-1:0]           r_q;
    logic [VAL_W-1:0]           r_sample;
    logic                       r_ended;
    logic [VAL_W-1:0]           r_out_sample;
    logic                       r_out_ended;

    logic                       zero_width;
    logic [TIME_W:0]            off_full;
    logic                       off_neg;
    logic [OFF_W-1:0]           mag_off;
    logic [HGT_W-1:0]           hgt;
    logic                       hgt_neg;
    logic [HGT_W-1:0]           mag_h;
    logic [TIME_W-1:0]          width;
    logic [OFF_W:0]             mul_sum;
    logic [TIME_W:0]            div_r2;
    logic [TIME_W:0]            div_diff;
    logic                       div_ge;
    logic [SUM_W-1:0]           sum_v;
    logic [VAL_W-1:0]           sum_sat;
    logic [TIME_W:0]            pos_sum;
    logic [TIME_W-1:0]          pos_new;
    logic                       advance;
    logic [IDX_W-1:0]           idx_next;
    logic [CMP_W-1:0]           pc_ext;
    logic [CMP_W-1:0]           n_use;
    logic                       in_range;

    // table port
    assign wr_ok   = {{(32 - begu_pkg::PIDX_W){1'b0}}, i_point_index} < 32'(MAX_POINTS);
    assign wr_addr = ADDR_W'(i_point_index);
    assign rd_addr = i_cmd.rd_right ? ADDR_W'(r_idx) : ADDR_W'(r_idx - 1'b1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_ok) begin
            r_mem[wr_addr] <= {i_point_time, i_point_value};
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // span geometry
    always_comb begin
        zero_width = (r_end_time <= r_start_time);
        width      = r_end_time - r_start_time;
        off_full   = {1'b0, r_pos} - {1'b0, r_start_time};
        off_neg    = off_full[TIME_W];
        mag_off    = off_neg ? OFF_W'(-off_full) : off_full[OFF_W-1:0];
        hgt        = {r_end_value[VAL_W-1], r_end_value}
                   - {r_start_value[VAL_W-1], r_start_value};
        hgt_neg    = hgt[HGT_W-1];
        mag_h      = hgt_neg ? -hgt : hgt;
    end

    // one multiplier bit and one quotient bit per step
    always_comb begin
        mul_sum  = r_p[PROD_W-1:HGT_W] + (r_p[0] ? {1'b0, r_a} : '0);
        div_r2   = {r_rem, r_p[PROD_W-1]};
        div_ge   = (div_r2 >= {1'b0, r_w});
        div_diff = div_r2 - {1'b0, r_w};
    end

    // start value plus or minus the scaled term, clamped to 32 bits
    always_comb begin
        sum_v = r_neg
              ? ({{(SUM_W - VAL_W){r_start_value[VAL_W-1]}}, r_start_value}
                 - {2'b00, r_q})
              : ({{(SUM_W - VAL_W){r_start_value[VAL_W-1]}}, r_start_value}
                 + {2'b00, r_q});
        if ((&sum_v[SUM_W-1:VAL_W-1]) || !(|sum_v[SUM_W-1:VAL_W-1])) begin
            sum_sat = sum_v[VAL_W-1:0];
        end else if (sum_v[SUM_W-1]) begin
            sum_sat = {1'b1, {(VAL_W - 1){1'b0}}};
        end else begin
            sum_sat = {1'b0, {(VAL_W - 1){1'b1}}};
        end
    end

    // position advance and span move
    always_comb begin
        pos_sum  = {1'b0, r_pos} + {1'b0, r_time_step};
        pos_new  = pos_sum[TIME_W] ? '1 : pos_sum[TIME_W-1:0];
        advance  = (pos_new > r_end_time);
        idx_next = r_idx + 1'b1;
        pc_ext   = CMP_W'(r_point_count);
        if (pc_ext < CMP_W'(2)) begin
            n_use = CMP_W'(2);
        end else if (pc_ext > CMP_W'(MAX_POINTS)) begin
            n_use = CMP_W'(MAX_POINTS);
        end else begin
            n_use = pc_ext;
        end
        in_range = (CMP_W'(idx_next) < n_use);
    end

    assign o_status.more_spans = r_more;
    assign o_status.zero_width = zero_width;
    assign o_status.reload     = advance && in_range;

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= begu_pkg::TIME_STEP_RESET;
            r_point_count <= begu_pkg::POINT_COUNT_RESET;
            r_pos         <= '0;
            r_idx         <= IDX_W'(1);
            r_more        <= 1'b0;
            r_start_time  <= '0;
            r_end_time    <= '0;
            r_start_value <= '0;
            r_end_value   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    begu_pkg::CFG_TIME_STEP:   r_time_step   <= i_cfg_data[TIME_W-1:0];
                    begu_pkg::CFG_POINT_COUNT: r_point_count <= i_cfg_data[begu_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.restart) begin
                r_pos  <= '0;
                r_idx  <= IDX_W'(1);
                r_more <= 1'b1;
            end
            if (i_cmd.update) begin
                r_pos <= pos_new;
                if (advance) begin
                    if (in_range) begin
                        r_idx <= idx_next;
                    end else begin
                        r_more <= 1'b0;
                    end
                end
            end
            if (i_cmd.cap_left) begin
                r_start_time  <= r_rd_data[MEM_W-1:VAL_W];
                r_start_value <= r_rd_data[VAL_W-1:0];
            end
            if (i_cmd.cap_right) begin
                r_end_time  <= r_rd_data[MEM_W-1:VAL_W];
                r_end_value <= r_rd_data[VAL_W-1:0];
            end
        end
    end

    // arithmetic and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.hold) begin
            r_sample <= r_end_value;
            r_ended  <= 1'b1;
        end
        if (i_cmd.prep) begin
            r_ended <= 1'b0;
            r_a     <= mag_off;
            r_p     <= PROD_W'(mag_h);
            r_w     <= width;
            r_neg   <= off_neg ^ hgt_neg;
            r_rem   <= '0;
            r_q     <= '0;
            if (zero_width) begin
                r_sample <= r_end_value;
            end
        end
        if (i_cmd.mul_step) begin
            r_p <= {1'b0, mul_sum, r_p[HGT_W-1:1]};
        end
        if (i_cmd.div_step) begin
            r_p   <= {r_p[PROD_W-2:0], 1'b0};
            r_rem <= div_ge ? div_diff[TIME_W-1:0] : div_r2[TIME_W-1:0];
            // quotient stops growing once it passes the saturating range
            if (!r_q[QUO_W-1]) begin
                r_q <= {r_q[QUO_W-2:0], div_ge};
            end
        end
        if (i_cmd.sum) begin
            r_sample <= sum_sat;
        end
        if (i_cmd.out_load) begin
            r_out_sample <= r_sample;
            r_out_ended  <= r_ended;
        end
    end

    assign o_sample = r_out_sample;
    assign o_ended  = r_out_ended;

endmodule

/* rtl/breakpoint_envelope_generator_unit.sv */
// ----------------------------------------------------------------------------
// breakpoint_envelope_generator_unit
// linear breakpoint envelope player with a loadable (time, value) table
// ----------------------------------------------------------------------------
// Write beats load one table entry without leaving the idle state; a restart
// beat fetches the first span. A tick before the spans start or after they
// run out returns the held end value. An interpolated tick runs a shift-add
// multiplier and a restoring divider one bit per cycle, then a sum and a
// position update; when the position crosses into the next span, both of its
// entries are fetched through the table's single read port. A zero-width span
// skips the multiply and divide. The result sits in an output register, so the
// next beat is taken while it waits.
module breakpoint_envelope_generator_unit #(
    parameter int MAX_POINTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [begu_pkg::ACT_W-1:0]          i_action,
    input  logic [begu_pkg::PIDX_W-1:0]         i_point_index,
    input  logic [begu_pkg::TIME_W-1:0]         i_point_time,
    input  logic signed [begu_pkg::VAL_W-1:0]   i_point_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [begu_pkg::VAL_W-1:0]   o_sample,
    output logic                                o_ended,
    input  logic                                i_cfg_we,
    input  logic [begu_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [begu_pkg::CFG_W-1:0]          i_cfg_data
);

    begu_pkg::t_dp_cmd      cmd;
    begu_pkg::t_dp_status   status;

    begu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    begu_datapath #(
        .MAX_POINTS (MAX_POINTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_point_index (i_point_index),
        .i_point_time  (i_point_time),
        .i_point_value (i_point_value),
        .o_sample      (o_sample),
        .o_ended       (o_ended)
    );

endmodule

/* rtl/begu_checker.sv */
// ----------------------------------------------------------------------------
// begu_checker
// port-level checks on beat sequencing, bound to the top level
// ----------------------------------------------------------------------------
`include "breakpoint_envelope_generator_unit_assert.svh"

module begu_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic [begu_pkg::ACT_W-1:0]          i_action,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [begu_pkg::VAL_W-1:0]   o_sample,
    input  logic                                o_ended
);

    logic in_beat;

    assign in_beat = i_in_valid && o_in_ready;

    // an accepted tick always leaves the block busy, with its input not ready
    `BEGU_ASSERT_NEXT(a_tick_busy, in_beat && (i_action == begu_pkg::ACT_TICK), !o_in_ready, "tick beat did not occupy the block")

    // table writes complete in the accepting cycle
    `BEGU_ASSERT_NEXT(a_write_ready, in_beat && (i_action == begu_pkg::ACT_WRITE), o_in_ready, "write beat stalled the input")

    // restart fetches a span and produces no result
    `BEGU_ASSERT_NEXT(a_restart_quiet, in_beat && (i_action == begu_pkg::ACT_RESTART) && !o_out_valid, !o_in_ready && !o_out_valid, "restart beat produced a result")

    // a new result appears only as the block finishes its work
    `BEGU_ASSERT_SAME(a_result_at_finish, $rose(o_out_valid), o_in_ready && $past(!o_in_ready), "result appeared outside the finish step")

    // stalled result beat holds its payload
    `BEGU_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_sample) && $stable(o_ended), "stalled result beat changed")

endmodule

bind breakpoint_envelope_generator_unit begu_checker u_begu_checker (.*);

/* tb/breakpoint_envelope_generator_unit_tb.sv */
// ----------------------------------------------------------------------------
// breakpoint_envelope_generator_unit_tb
// self-checking bench for the breakpoint envelope player: tracks the table,
// span and position in a small scoreboard class, predicts every tick's sample
// and ended flag, and checks each output beat in order while both handshakes
// idle and stall at random
// ----------------------------------------------------------------------------
module breakpoint_envelope_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import begu_pkg::*;

    localparam int MAX_PTS         = 64;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int IDLE_GUARD      = 160;
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int ITEM_TARGET     = 550;

    localparam logic [ACT_W-1:0]  ACT_UNUSED = 2'd3;
    localparam logic [TIME_W-1:0] TIME_MAX   = '1;
    localparam longint SAMPLE_MAX = 64'sd2147483647;
    localparam longint SAMPLE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample;
        logic                    ended;
    } t_env_result;

    class envelope_tracker;
        logic [TIME_W-1:0]       bp_time [MAX_PTS];
        logic signed [VAL_W-1:0] bp_value [MAX_PTS];
        bit                      bp_written [MAX_PTS];
        logic [TIME_W-1:0]       position;
        logic [TIME_W-1:0]       step;
        logic [CNT_W-1:0]        count_reg;
        logic [TIME_W-1:0]       left_time;
        logic [TIME_W-1:0]       right_time;
        logic signed [VAL_W-1:0] left_value;
        logic signed [VAL_W-1:0] right_value;
        int unsigned             right_idx;
        bit                      playing;
        t_env_result             expected_q[$];
        int unsigned             mismatches;

        function new();
            foreach (bp_written[i]) bp_written[i] = 1'b0;
            position    = '0;
            step        = TIME_STEP_RESET;
            count_reg   = POINT_COUNT_RESET;
            left_time   = '0;
            right_time  = '0;
            left_value  = '0;
            right_value = '0;
            right_idx   = 1;
            playing     = 1'b0;
            mismatches  = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_TIME_STEP:   step = data[TIME_W-1:0];
                CFG_POINT_COUNT: count_reg = data[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned points_used();
            int unsigned n;
            n = count_reg;
            if (n < 2) n = 2;
            if (n > MAX_PTS) n = MAX_PTS;
            return n;
        endfunction

        // a tick may move into the next span, which reads two table entries
        function bit tick_safe();
            if (!playing) return 1'b1;
            if (right_idx + 1 >= points_used()) return 1'b1;
            return bp_written[right_idx] && bp_written[right_idx + 1];
        endfunction

        function void note_beat(logic [ACT_W-1:0] action, logic [PIDX_W-1:0] idx,
                                logic [TIME_W-1:0] t, logic signed [VAL_W-1:0] v);
            t_env_result res;
            logic [TIME_W:0] sum;
            logic [TIME_W-1:0] width;
            logic [79:0] mag_off, mag_h, quo;
            longint offset, height, total;
            bit neg;
            case (action)
                ACT_WRITE: begin
                    bp_time[idx]    = t;
                    bp_value[idx]   = v;
                    bp_written[idx] = 1'b1;
                end
                ACT_RESTART: begin
                    position    = '0;
                    right_idx   = 1;
                    left_time   = bp_time[0];
                    left_value  = bp_value[0];
                    right_time  = bp_time[1];
                    right_value = bp_value[1];
                    playing     = 1'b1;
                end
                ACT_TICK: begin
                    if (!playing) begin
                        res.sample = right_value;
                        res.ended  = 1'b1;
                        expected_q.push_back(res);
                        return;
                    end
                    if (right_time <= left_time) begin
                        res.sample = right_value;
                    end else begin
                        // exact product over width, truncated, capped at 2^40
                        width   = right_time - left_time;
                        offset  = longint'(position) - longint'(left_time);
                        height  = longint'(right_value) - longint'(left_value);
                        mag_off = 80'(offset < 0 ? -offset : offset);
                        mag_h   = 80'(height < 0 ? -height : height);
                        neg     = (offset < 0) != (height < 0);
                        quo     = (mag_off * mag_h) / 80'(width);
                        if (quo > (80'd1 << TIME_W)) quo = 80'd1 << TIME_W;
                        total = neg ? longint'(left_value) - longint'(quo[TIME_W:0])
                                    : longint'(left_value) + longint'(quo[TIME_W:0]);
                        if (total > SAMPLE_MAX) total = SAMPLE_MAX;
                        if (total < SAMPLE_MIN) total = SAMPLE_MIN;
                        res.sample = total[VAL_W-1:0];
                    end
                    res.ended = 1'b0;
                    expected_q.push_back(res);

                    sum      = {1'b0, position} + {1'b0, step};
                    position = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
                    if (position > right_time) begin
                        right_idx++;
                        if (right_idx < points_used()) begin
                            left_time   = bp_time[right_idx - 1];
                            left_value  = bp_value[right_idx - 1];
                            right_time  = bp_time[right_idx];
                            right_value = bp_value[right_idx];
                        end else begin
                            playing = 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic signed [VAL_W-1:0] sample, logic ended);
            t_env_result want;
            if (expected_q.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected output beat: sample %h ended %b", sample, ended);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (sample !== want.sample || ended !== want.ended) begin
                if (mismatches < 10)
                    $display("output mismatch: sample exp %h got %h, ended exp %b got %b",
                             want.sample, sample, want.ended, ended);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [ACT_W-1:0]         i_action;
    logic [PIDX_W-1:0]        i_point_index;
    logic [TIME_W-1:0]        i_point_time;
    logic signed [VAL_W-1:0]  i_point_value;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic signed [VAL_W-1:0]  o_sample;
    logic                     o_ended;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_W-1:0]         i_cfg_data;

    logic                     hold_off_req = 1'b0;
    int unsigned              items_sent = 0;
    envelope_tracker          tracker = new();

    breakpoint_envelope_generator_unit #(
        .MAX_POINTS(MAX_PTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_point_index (i_point_index),
        .i_point_time  (i_point_time),
        .i_point_value (i_point_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_sample      (o_sample),
        .o_ended       (o_ended),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned rand_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 4);
        if (r < 98) return $urandom_range(5, 30);
        return $urandom_range(60, 300);
    endfunction

    function automatic logic [TIME_W-1:0] rand40();
        return TIME_W'({$urandom, $urandom});
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic [ACT_W-1:0] action, input logic [PIDX_W-1:0] idx,
                             input logic [TIME_W-1:0] t, input logic [VAL_W-1:0] v,
                             input bit burst);
        int unsigned gap;
        gap = burst ? 0 : rand_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= action;
        i_point_index <= idx;
        i_point_time  <= t;
        i_point_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_beat(action, idx, t, v);
        if (action != ACT_UNUSED) items_sent++;
    endtask

    // nothing in flight once every tick has returned and the guard has run out
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.expected_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_GUARD) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [TIME_W-1:0] step, input int unsigned count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_TIME_STEP;
        i_cfg_data  <= CFG_W'(step);
        @(posedge i_clk);
        tracker.set_reg(CFG_TIME_STEP, CFG_W'(step));
        i_cfg_index <= CFG_POINT_COUNT;
        i_cfg_data  <= CFG_W'(count);
        @(posedge i_clk);
        tracker.set_reg(CFG_POINT_COUNT, CFG_W'(count));
        i_cfg_we    <= 1'b0;
    endtask

    // load a table (whole on first pass, a few entries later), restart, play out
    task automatic play_sequence(input bit first, input bit burst);
        logic [TIME_W-1:0] tab_time [MAX_PTS];
        logic [VAL_W-1:0]  tab_value [MAX_PTS];
        logic [63:0]       acc, stride;
        int unsigned       n, k, idx, ticks, held;
        n      = tracker.points_used();
        stride = 64'(tracker.step);
        acc    = ($urandom_range(0, 2) == 0) ? 64'(rand40()) % (stride + 1) : 64'd0;
        for (int i = 0; i < n; i++) begin
            if (acc > 64'(TIME_MAX)) acc = 64'(TIME_MAX);
            tab_time[i]  = acc[TIME_W-1:0];
            tab_value[i] = rand_value();
            // now and then a point out of order, giving a reversed span
            if ($urandom_range(0, 15) == 0) tab_time[i] = rand40();
            if ($urandom_range(0, 7) != 0)
                acc = acc + stride * $urandom_range(0, 3) + 64'(rand40()) % (stride + 1);
        end
        if (first) begin
            for (int i = 0; i < n; i++)
                send_beat(ACT_WRITE, PIDX_W'(i), tab_time[i], tab_value[i], burst);
        end else begin
            k = $urandom_range(1, (n < 6) ? n : 6);
            repeat (k) begin
                idx = $urandom_range(0, n - 1);
                send_beat(ACT_WRITE, PIDX_W'(idx), tab_time[idx], tab_value[idx], burst);
            end
        end
        send_beat(ACT_RESTART, PIDX_W'($urandom), rand40(), $urandom, burst);
        ticks = 0;
        held  = 0;
        while (ticks < 80 && held < 2 && tracker.tick_safe()) begin
            send_beat(ACT_TICK, PIDX_W'($urandom), rand40(), $urandom, burst);
            ticks++;
            if (!tracker.playing) held++;
        end
    endtask

    initial begin : watchdog
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_sample(o_sample, o_ended);
    end

    initial begin : out_ready_drive
        bit hold_off_done;
        hold_off_done = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                // long back-pressure so the block fills and stalls its input
                i_out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat (rand_gap() + 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 200)) @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] step_cfg;
        logic [ACT_W-1:0]  noise_act;
        int unsigned       count_cfg, phase, phase_start;
        bit                burst;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_TICK;
        i_point_index <= '0;
        i_point_time  <= '0;
        i_point_value <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_TIME_STEP;
        i_cfg_data    <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick before any restart gives the held end value
        send_beat(ACT_TICK, '0, '0, '0, 1'b0);
        // full-scale span across the whole time range
        send_beat(ACT_WRITE, PIDX_W'(0), '0, 32'h8000_0000, 1'b0);
        send_beat(ACT_WRITE, PIDX_W'(1), TIME_MAX, 32'h7FFF_FFFF, 1'b0);
        send_beat(ACT_RESTART, '0, '0, '0, 1'b0);
        repeat (2) send_beat(ACT_TICK, '1, TIME_MAX, '1, 1'b0);
        // zero-width span, then held end
        send_beat(ACT_WRITE, PIDX_W'(1), '0, 32'h1234_5678, 1'b0);
        send_beat(ACT_RESTART, '0, '0, '0, 1'b0);
        repeat (2) send_beat(ACT_TICK, '0, '0, '0, 1'b0);
        // reversed span
        send_beat(ACT_WRITE, PIDX_W'(0), TIME_W'(1000), '0, 1'b0);
        send_beat(ACT_WRITE, PIDX_W'(1), TIME_W'(10), VAL_W'(100), 1'b0);
        send_beat(ACT_RESTART, '0, '0, '0, 1'b0);
        repeat (2) send_beat(ACT_TICK, '0, '0, '0, 1'b0);
        send_beat(ACT_UNUSED, '1, TIME_MAX, '1, 1'b0);
        // big step lands far past a one-unit span: extrapolation saturates both ways
        wait_idle();
        write_regs(TIME_W'(64'd1 << 30), 3);
        send_beat(ACT_WRITE, PIDX_W'(0), TIME_W'(0), '0, 1'b0);
        send_beat(ACT_WRITE, PIDX_W'(1), TIME_W'(1), '0, 1'b0);
        send_beat(ACT_WRITE, PIDX_W'(2), TIME_W'(2), 32'h7FFF_FFFF, 1'b0);
        send_beat(ACT_RESTART, '0, '0, '0, 1'b0);
        repeat (3) send_beat(ACT_TICK, '0, '0, '0, 1'b0);
        send_beat(ACT_WRITE, PIDX_W'(2), TIME_W'(2), 32'h8000_0000, 1'b0);
        send_beat(ACT_RESTART, '0, '0, '0, 1'b0);
        repeat (3) send_beat(ACT_TICK, '0, '0, '0, 1'b0);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case (phase)
                0: begin step_cfg = TIME_W'(1);  count_cfg = 2;   end
                1: begin step_cfg = TIME_MAX;    count_cfg = 64;  end
                2: begin step_cfg = TIME_W'($urandom_range(1000, 1 << 24)); count_cfg = 5; end
                3: begin step_cfg = rand40();    count_cfg = 0;   end
                4: begin step_cfg = TIME_W'($urandom_range(1, 1 << 20)); count_cfg = 127; end
                default: begin
                    step_cfg  = $urandom_range(0, 1) ? rand40()
                                                     : TIME_W'($urandom_range(1, 1 << 22));
                    count_cfg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                            : $urandom_range(2, 10);
                end
            endcase
            if (step_cfg == '0) step_cfg = TIME_W'(1);
            wait_idle();
            write_regs(step_cfg, count_cfg);
            burst = (phase == 2) || ($urandom_range(0, 3) == 0);
            if (phase == 2) hold_off_req <= 1'b1;
            phase_start = items_sent;
            play_sequence(1'b1, burst);
            while (items_sent - phase_start < 50) begin
                if ($urandom_range(0, 3) == 0) begin
                    // stray beats between sequences
                    repeat ($urandom_range(1, 4)) begin
                        noise_act = ACT_W'($urandom_range(0, 3));
                        if ((noise_act == ACT_TICK && !tracker.tick_safe()) ||
                            (noise_act == ACT_RESTART &&
                             !(tracker.bp_written[0] && tracker.bp_written[1])))
                            noise_act = ACT_WRITE;
                        send_beat(noise_act, PIDX_W'($urandom), rand40(), rand_value(), burst);
                    end
                end else begin
                    play_sequence(1'b0, burst);
                end
            end
            phase++;
        end

        wait_idle();
        if (tracker.mismatches == 0 && tracker.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
